/* sv/dws_pkg.sv */
// ---------------------------------------------------------------------------
// dws_pkg
// Shared types and constants for the double-ended queue with search.
// ---------------------------------------------------------------------------
package dws_pkg;

   localparam int FUNC_W      = 3;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int POS_W       = 5;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = STATUS_W;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_FRONT = 3'd0,
      FN_PUSH_BACK  = 3'd1,
      FN_POP_FRONT  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_SEARCH     = 3'd4,
      FN_DUMP       = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      UPD_NONE,
      UPD_PUSH_FRONT,
      UPD_PUSH_BACK,
      UPD_POP_FRONT,
      UPD_POP_BACK
   } upd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_SEARCH,
      S_DUMP
   } state_type;

   typedef struct packed {
      upd_type    upd;
      logic       scan_start;
      logic       scan_step;
      logic       emit;
      status_type emit_status;
      logic       emit_data;
      logic       emit_pos;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic match;
      logic scan_last;
      logic out_free;
   } stat_type;

endpackage

/* sv/dws_ctrl.sv */
// ---------------------------------------------------------------------------
// dws_ctrl
// Sequencer: decodes each request beat and steps pops, searches and dumps.
// ---------------------------------------------------------------------------
module dws_ctrl
   import dws_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  func_type req_func,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.upd       = UPD_NONE;
      cmd.emit_last = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               unique case (req_func) inside
                  FN_PUSH_FRONT, FN_PUSH_BACK: begin
                     cmd.emit = 1'b1;
                     if (stat.full) begin
                        cmd.emit_status = ST_FULL;
                     end else begin
                        cmd.emit_status = ST_OK;
                        cmd.upd = (req_func == FN_PUSH_FRONT) ? UPD_PUSH_FRONT
                                                              : UPD_PUSH_BACK;
                     end
                  end
                  FN_POP_FRONT, FN_POP_BACK: begin
                     if (stat.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_EMPTY;
                     end else begin
                        cmd.upd  = (req_func == FN_POP_FRONT) ? UPD_POP_FRONT
                                                              : UPD_POP_BACK;
                        state_in = S_POP;
                     end
                  end
                  FN_SEARCH, FN_DUMP: begin
                     if (stat.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_EMPTY;
                     end else begin
                        cmd.scan_start = 1'b1;
                        state_in = (req_func == FN_SEARCH) ? S_SEARCH : S_DUMP;
                     end
                  end
                  default: begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_OK;
                  end
               endcase
            end
         end
         S_POP: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_OK;
               cmd.emit_data   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_SEARCH: begin
            if (stat.match) begin
               if (stat.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_OK;
                  cmd.emit_pos    = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (stat.scan_last) begin
               if (stat.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_NOTFOUND;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_DUMP: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_OK;
               cmd.emit_data   = 1'b1;
               cmd.emit_last   = stat.scan_last;
               if (stat.scan_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.scan_step = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* sv/dws_datapath.sv */
// ---------------------------------------------------------------------------
// dws_datapath
// Ring store, front index, entry count, scan pointer and result register.
// ---------------------------------------------------------------------------
module dws_datapath
   import dws_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_ready,
   output stat_type                  stat,
   output logic                      rsp_valid,
   output status_type                rsp_status,
   output logic signed [VALUE_W-1:0] rsp_data,
   output logic [POS_W-1:0]          rsp_position,
   output logic [POS_W-1:0]          rsp_entry_count,
   output logic                      rsp_last
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = ((IW > CW) ? IW : CW) + 1;
   localparam int EW = (CW > POS_W) ? CW : POS_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   logic signed [VALUE_W-1:0] mem [DEPTH];

   logic [IW-1:0]             front_ff, front_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [IW-1:0]             ptr_ff, ptr_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      out_valid_ff, out_valid_in;
   status_type                out_status_ff;
   logic signed [VALUE_W-1:0] out_data_ff;
   logic [POS_W-1:0]          out_pos_ff;
   logic [POS_W-1:0]          out_count_ff;
   logic                      out_last_ff;

   logic [IW-1:0] front_dec, front_inc, ptr_next, tail_addr, back_addr;
   logic [SW-1:0] tail_sum, back_sum;
   logic [IW-1:0] rd_addr, wr_addr;
   logic          rd_en, wr_en;
   logic [EW-1:0] pos_ext, count_ext;

   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - IW'(1);
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + IW'(1);
   assign ptr_next  = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + IW'(1);

   assign tail_sum  = SW'(front_ff) + SW'(count_ff);
   assign back_sum  = tail_sum - SW'(1);
   assign tail_addr = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
   assign back_addr = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CW'(DEPTH));
   assign stat.match     = (rd_data_ff == key_ff);
   assign stat.scan_last = (idx_ff == count_ff - CW'(1));
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      rd_addr  = front_ff;
      wr_addr  = tail_addr;
      case (cmd.upd)
         UPD_PUSH_FRONT: begin
            front_in = front_dec;
            count_in = count_ff + CW'(1);
            wr_en    = 1'b1;
            wr_addr  = front_dec;
         end
         UPD_PUSH_BACK: begin
            count_in = count_ff + CW'(1);
            wr_en    = 1'b1;
         end
         UPD_POP_FRONT: begin
            front_in = front_inc;
            count_in = count_ff - CW'(1);
            rd_en    = 1'b1;
         end
         UPD_POP_BACK: begin
            count_in = count_ff - CW'(1);
            rd_en    = 1'b1;
            rd_addr  = back_addr;
         end
         default: ;
      endcase
      if (cmd.scan_start) begin
         ptr_in = front_ff;
         idx_in = '0;
         key_in = req_value;
         rd_en  = 1'b1;
      end
      if (cmd.scan_step) begin
         ptr_in  = ptr_next;
         idx_in  = idx_ff + CW'(1);
         rd_en   = 1'b1;
         rd_addr = ptr_next;
      end
   end

   assign pos_ext   = EW'(idx_ff + CW'(1));
   assign count_ext = EW'(count_in);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      idx_ff <= idx_in;
      key_ff <= key_in;
      if (cmd.emit) begin
         out_status_ff <= cmd.emit_status;
         out_data_ff   <= cmd.emit_data ? rd_data_ff : '0;
         out_pos_ff    <= cmd.emit_pos ? pos_ext[POS_W-1:0] : '0;
         out_count_ff  <= count_ext[POS_W-1:0];
         out_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_data        = out_data_ff;
   assign rsp_position    = out_pos_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_last        = out_last_ff;

endmodule

/* sv/deque_with_search_top.sv */
// ---------------------------------------------------------------------------
// deque_with_search_top
// Bounded double-ended queue of signed 32-bit values with search and dump.
// ---------------------------------------------------------------------------
// Request beats on req_* carry an operation code and a value. Each request
// gives one response beat on rsp_*, except a dump of a non-empty queue,
// which gives one beat per entry, front to back, with tlast on the final
// one. Every response carries the entry count after the operation.
// Push, and any request that only reports a status, is taken at once
// and its response is registered on the next edge. A pop first reads the
// ring store into a register; its response is registered after that.
// Search and dump read the ring store one entry per cycle, but a dump
// waits while the response register is full. A new request is taken
// only once the previous one is fully answered and the response register
// is free or being drained in that cycle. Reset empties the queue; store
// contents are not cleared. When the receiver holds rsp_tready low, the
// response beat holds and the scan pauses until it is taken.
// ---------------------------------------------------------------------------
module deque_with_search_top
   import dws_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // func, value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // data, position, entry_count
   output logic [RSP_TUSER_W-1:0] rsp_tuser,  // status
   output logic                   rsp_tlast
);

   cmd_type                   cmd;
   stat_type                  stat;
   func_type                  req_func;
   logic signed [VALUE_W-1:0] req_value;
   status_type                rsp_status;
   logic signed [VALUE_W-1:0] rsp_data;
   logic [POS_W-1:0]          rsp_position;
   logic [POS_W-1:0]          rsp_entry_count;

   assign req_func  = func_type'(req_tdata[FUNC_W-1:0]);
   assign req_value = req_tdata[FUNC_W +: VALUE_W];

   dws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_func),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dws_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_value       (req_value),
      .rsp_ready       (rsp_tready),
      .stat            (stat),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_status),
      .rsp_data        (rsp_data),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_TDATA_W - VALUE_W - 2 * POS_W)'(0),
                       rsp_entry_count, rsp_position, rsp_data};
   assign rsp_tuser = rsp_status;

endmodule

/* sv/dws_checker.sv */
// ---------------------------------------------------------------------------
// dws_checker
// Port-level checks for the deque, bound to the top level.
// ---------------------------------------------------------------------------
module dws_checker
   import dws_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser,
   input logic                   rsp_tlast
);

   logic [POS_W-1:0] cnt;
   logic [POS_W-1:0] pos;

   assign cnt = rsp_tdata[VALUE_W+POS_W +: POS_W];
   assign pos = rsp_tdata[VALUE_W +: POS_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |-> cnt == POS_W'(DEPTH) && rsp_tlast)
      else $error("full status with wrong entry count");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_EMPTY |-> cnt == '0 && rsp_tlast && pos == '0)
      else $error("empty status with entries or position");

   a_mid_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == ST_OK && pos == '0 && cnt != '0)
      else $error("non-final beat that is not a dump entry");

   a_no_req_mid_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |-> !req_tready)
      else $error("request taken while a dump is in progress");

endmodule

bind deque_with_search_top dws_checker #(.DEPTH(DEPTH)) u_dws_checker (.*);

/* test/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded double-ended queue with search/dump.
// ---------------------------------------------------------------------------
// Request beats come from a pending queue and are driven on the falling
// edge. Each accepted request goes through a local deque model, which
// queues the response beats it should produce. Response beats are checked
// field by field, in order, on the rising edge. A short directed sequence
// covers the empty, single-entry and duplicate cases. Fill/drain bursts,
// searches, dumps and loose ops follow across four idle/stall mixes. One
// long response hold-off backs the block up into its request port.
// ---------------------------------------------------------------------------
module tb_top;
   import dws_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
   localparam int ITEMS_PER_PHASE = 112;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
   } deque_req_type;

   typedef struct {
      status_type         status;
      logic [VALUE_W-1:0] data;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   entry_count;
      logic               last;
   } deque_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // func, value
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // data, position, entry_count
   logic [RSP_TUSER_W-1:0] rsp_tuser;        // status
   logic                   rsp_tlast;

   deque_with_search_top #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and generator-side shadow of queue contents
   deque_req_type      pending_reqs[$];
   logic [VALUE_W-1:0] gen_shadow[$];
   int                 n_generated = 0;
   int                 send_idle_pct = 0;
   int                 stall_pct = 0;
   bit                 hold_go = 1'b0;

   // model state
   logic [VALUE_W-1:0] ring[DEPTH];
   int                 head = 0;
   int                 fill = 0;
   deque_rsp_type      due_results[$];

   // bookkeeping
   bit req_taken = 1'b0;
   int err_count = 0;
   int n_accepted = 0;
   int n_beats = 0;
   int n_full = 0;
   int n_empty = 0;
   int n_notfound = 0;
   int n_found = 0;
   int peak_fill = 0;

   function automatic int slot(input int off);
      return (head + off) % DEPTH;
   endfunction

   task automatic apply_deque_op(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] v);
      deque_rsp_type r;
      int            i;
      bit            hit;
      r.status = ST_OK;
      r.data = '0;
      r.position = '0;
      r.last = 1'b1;
      hit = 1'b0;
      case (fn) inside
         FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               r.status = ST_FULL;
               n_full++;
            end else begin
               if (fn == FN_PUSH_FRONT) begin
                  head = (head + DEPTH - 1) % DEPTH;
                  ring[head] = v;
               end else begin
                  ring[slot(fill)] = v;
               end
               fill++;
            end
         end
         FN_POP_FRONT, FN_POP_BACK: begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
               n_empty++;
            end else begin
               if (fn == FN_POP_FRONT) begin
                  r.data = ring[head];
                  head = slot(1);
               end else begin
                  r.data = ring[slot(fill - 1)];
               end
               fill--;
            end
         end
         FN_SEARCH: begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
               n_empty++;
            end else begin
               r.status = ST_NOTFOUND;
               for (i = 0; i < fill; i++) begin
                  if (!hit && ring[slot(i)] == v) begin
                     hit = 1'b1;
                     r.status = ST_OK;
                     r.position = POS_W'(i + 1);
                  end
               end
               if (hit) n_found++;
               else n_notfound++;
            end
         end
         FN_DUMP: begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
               n_empty++;
            end else begin
               for (i = 0; i < fill; i++) begin
                  r.data = ring[slot(i)];
                  r.last = (i == fill - 1);
                  r.entry_count = POS_W'(fill);
                  due_results.push_back(r);
               end
               return;
            end
         end
         default: ;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      r.entry_count = POS_W'(fill);
      due_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      if (err_count < 40)
         $display("[%0t] mismatch on beat %0d, %s: got %0h, expected %0h",
                  $realtime, n_beats, what, got, want);
      err_count++;
   endtask

   // rising edge: take request beats into the model, check response beats
   always @(posedge clock) begin
      deque_rsp_type want;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_deque_op(req_tdata[FUNC_W-1:0], req_tdata[FUNC_W +: VALUE_W]);
            n_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               report_mismatch("beat with nothing outstanding", rsp_tdata[31:0], '0);
            end else begin
               want = due_results.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", VALUE_W'(rsp_tuser), VALUE_W'(want.status));
               if (rsp_tdata[31:0] !== want.data)
                  report_mismatch("data", rsp_tdata[31:0], want.data);
               if (rsp_tdata[36:32] !== want.position)
                  report_mismatch("position", VALUE_W'(rsp_tdata[36:32]),
                                  VALUE_W'(want.position));
               if (rsp_tdata[41:37] !== want.entry_count)
                  report_mismatch("entry_count", VALUE_W'(rsp_tdata[41:37]),
                                  VALUE_W'(want.entry_count));
               if (rsp_tlast !== want.last)
                  report_mismatch("tlast", VALUE_W'(rsp_tlast), VALUE_W'(want.last));
            end
            n_beats++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      deque_req_type it;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            it = pending_reqs.pop_front();
            req_tdata <= {{(REQ_TDATA_W - FUNC_W - VALUE_W){1'b0}}, it.value, it.func};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off
   int hold_left = 0;
   bit hold_used = 1'b0;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic add_item(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] v);
      deque_req_type it;
      it.func = fn;
      it.value = v;
      pending_reqs.push_back(it);
      n_generated++;
      case (fn)
         FN_PUSH_FRONT: if (gen_shadow.size() < DEPTH) gen_shadow.push_front(v);
         FN_PUSH_BACK:  if (gen_shadow.size() < DEPTH) gen_shadow.push_back(v);
         FN_POP_FRONT:  if (gen_shadow.size() > 0) void'(gen_shadow.pop_front());
         FN_POP_BACK:   if (gen_shadow.size() > 0) void'(gen_shadow.pop_back());
         default: ;
      endcase
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9)) inside
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4, 5: return VALUE_W'($urandom_range(0, 7));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] search_value();
      if (gen_shadow.size() != 0 && $urandom_range(0, 9) < 7)
         return gen_shadow[$urandom_range(0, gen_shadow.size() - 1)];
      return pick_value();
   endfunction

   task automatic add_push();
      add_item($urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT, pick_value());
   endtask

   task automatic add_pop();
      add_item($urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT, '0);
   endtask

   task automatic add_random_phase(input int target);
      int n;
      while (n_generated < target) begin
         case ($urandom_range(0, 11)) inside
            0: begin
               while (gen_shadow.size() < DEPTH) add_push();
               n = $urandom_range(1, 2);
               repeat (n) add_push();
            end
            1: begin
               while (gen_shadow.size() > 0) add_pop();
               n = $urandom_range(1, 2);
               repeat (n) add_pop();
            end
            2, 3, 4: add_item(FN_SEARCH, search_value());
            5: add_item(FN_DUMP, $urandom);
            6, 7, 8: add_push();
            9, 10: add_pop();
            default: add_item(FN_SPARE_A | 3'($urandom_range(0, 7)), $urandom);
         endcase
      end
   endtask

   task automatic wait_sent();
      while (pending_reqs.size() != 0 || req_tvalid) @(posedge clock);
   endtask

   initial begin
      int ph;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty cases, spare codes, single entry, extremes, duplicates
      add_item(FN_POP_FRONT, 32'h1234_5678);
      add_item(FN_POP_BACK, '0);
      add_item(FN_SEARCH, '0);
      add_item(FN_DUMP, '0);
      add_item(FN_SPARE_A, 32'hffff_ffff);
      add_item(FN_SPARE_B, 32'h5555_aaaa);
      add_item(FN_PUSH_BACK, 32'h7fff_ffff);
      add_item(FN_PUSH_FRONT, 32'h8000_0000);
      add_item(FN_DUMP, '0);
      add_item(FN_SEARCH, 32'h8000_0000);
      add_item(FN_SEARCH, 32'h0000_0001);
      add_item(FN_POP_BACK, '0);
      add_item(FN_POP_FRONT, '0);
      add_item(FN_DUMP, '0);
      add_item(FN_PUSH_BACK, 32'hffff_ffff);
      add_item(FN_PUSH_BACK, 32'h0000_0000);
      add_item(FN_PUSH_FRONT, 32'h0000_0000);
      add_item(FN_SEARCH, 32'h0000_0000);
      add_item(FN_SEARCH, 32'hffff_ffff);
      add_item(FN_SPARE_B, '0);
      add_item(FN_DUMP, '0);
      add_item(FN_POP_BACK, '0);
      add_item(FN_POP_FRONT, '0);
      add_item(FN_POP_FRONT, '0);
      wait_sent();

      // hold-off while the sender keeps offering
      hold_go = 1'b1;
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 60; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 60; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         add_random_phase(n_generated + ITEMS_PER_PHASE);
         wait_sent();
      end

      while (due_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d requests and %0d response beats; peak fill %0d of %0d.",
               n_accepted, n_beats, peak_fill, DEPTH);
      $display("Full pushes %0d, empty ops %0d, search hits %0d, misses %0d.",
               n_full, n_empty, n_found, n_notfound);
      if (err_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d beats outstanding.", due_results.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
